/* design/vbl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbl_pkg
// Shared types, constants and helper functions for the velocity bin level
// map and peak tracker.
// ----------------------------------------------------------------------------
package vbl_pkg;

	// Radial geometry.
	localparam int MAX_BINS = 1024;

	// Field widths.
	localparam int SAMPLE_W = 16;
	localparam int BIN_W    = 10;
	localparam int LEVEL_W  = 8;
	localparam int MODE_W   = 2;
	localparam int CODE_W   = 8;
	localparam int INV_W    = 10;

	// Packed stream widths.
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 40;

	// Configuration port.
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// Register indexes.
	localparam logic [1:0] REG_MODE    = 2'd0;
	localparam logic [1:0] REG_BIAS    = 2'd1;
	localparam logic [1:0] REG_FOLDED  = 2'd2;
	localparam logic [1:0] REG_INVALID = 2'd3;

	// Resolution mode codes.
	localparam logic [MODE_W-1:0] MODE_HALF_MPS = 2'd1;

	// Reset values.
	localparam logic [MODE_W-1:0] MODE_RESET    = MODE_HALF_MPS;
	localparam logic [CODE_W-1:0] BIAS_RESET    = 8'd129;
	localparam logic [CODE_W-1:0] FOLDED_RESET  = 8'd1;
	localparam logic [INV_W-1:0]  INVALID_RESET = 10'd256;

	// Level clamp limits in doubling mode.
	localparam logic signed [10:0] LEVEL_MIN = 11'sd2;
	localparam logic signed [10:0] LEVEL_MAX = 11'sd255;

	// Configuration registers as seen by the datapath.
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [CODE_W-1:0] bias;
		logic [CODE_W-1:0] folded;
		logic [INV_W-1:0]  invalid;
	} vbl_cfg_t;

	// One input item.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic [BIN_W-1:0]           bin_index;
		logic [BIN_W-1:0]           first_good;
		logic [BIN_W-1:0]           last_good;
		logic                       new_cut;
	} vbl_item_t;

	// Display level of one sample that lies inside the good window.
	function automatic logic [LEVEL_W-1:0] map_level(
		input logic signed [SAMPLE_W-1:0] s,
		input logic [MODE_W-1:0]          mode,
		input logic [CODE_W-1:0]          bias
	);
		logic [LEVEL_W-1:0] s8;
		logic signed [10:0] p;
		logic [LEVEL_W-1:0] lvl;
		s8 = s[LEVEL_W-1:0];
		p  = $signed({2'b00, s8, 1'b0}) - $signed({3'b000, bias});
		if (s[SAMPLE_W-1:LEVEL_W] != '0) begin
			lvl = '0;
		end else if (mode == MODE_HALF_MPS) begin
			lvl = s8;
		end else if (s8 <= 8'd1) begin
			lvl = s8;
		end else if (p < LEVEL_MIN) begin
			lvl = LEVEL_MIN[LEVEL_W-1:0];
		end else if (p > LEVEL_MAX) begin
			lvl = LEVEL_MAX[LEVEL_W-1:0];
		end else begin
			lvl = p[LEVEL_W-1:0];
		end
		return lvl;
	endfunction

endpackage

/* design/vbl_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbl_cfg
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module vbl_cfg
	import vbl_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output vbl_cfg_t           cfg
);

	logic [1:0] reg_idx;
	logic       wr_en;
	vbl_cfg_t   cfg_q;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign wr_en   = psel & penable & pwrite & pready;

	// Register writes in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode    <= MODE_RESET;
			cfg_q.bias    <= BIAS_RESET;
			cfg_q.folded  <= FOLDED_RESET;
			cfg_q.invalid <= INVALID_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MODE:    cfg_q.mode    <= pwdata[MODE_W-1:0];
				REG_BIAS:    cfg_q.bias    <= pwdata[CODE_W-1:0];
				REG_FOLDED:  cfg_q.folded  <= pwdata[CODE_W-1:0];
				REG_INVALID: cfg_q.invalid <= pwdata[INV_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back.
	always_comb begin
		case (reg_idx)
			REG_MODE:    prdata = PDATA_W'(cfg_q.mode);
			REG_BIAS:    prdata = PDATA_W'(cfg_q.bias);
			REG_FOLDED:  prdata = PDATA_W'(cfg_q.folded);
			REG_INVALID: prdata = PDATA_W'(cfg_q.invalid);
			default:     prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

/* design/vbl_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbl_core
// Input register, level mapping and peak update, result register.
// ----------------------------------------------------------------------------
module vbl_core
	import vbl_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  vbl_cfg_t                    cfg,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  vbl_item_t                   in_item,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [LEVEL_W-1:0]          out_level,
	output logic signed [SAMPLE_W-1:0]  out_neg,
	output logic signed [SAMPLE_W-1:0]  out_pos
);

	logic                       valid_s1;
	vbl_item_t                  item_s1;
	logic                       valid_s2;
	logic [LEVEL_W-1:0]         level_s2;
	logic signed [SAMPLE_W-1:0] neg_peak_q;
	logic signed [SAMPLE_W-1:0] pos_peak_q;

	logic                       advance;
	logic                       in_win;
	logic                       trackable;
	logic signed [SAMPLE_W-1:0] bias_s;
	logic signed [SAMPLE_W-1:0] neg_base;
	logic signed [SAMPLE_W-1:0] pos_base;
	logic signed [SAMPLE_W-1:0] neg_next;
	logic signed [SAMPLE_W-1:0] pos_next;
	logic [LEVEL_W-1:0]         level_next;

	// Stage one moves on when the result register is free or being drained.
	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	// Window test and the signed compares against the code registers.
	assign bias_s    = $signed({{(SAMPLE_W-CODE_W){1'b0}}, cfg.bias});
	assign in_win    = (item_s1.bin_index >= item_s1.first_good)
		&& (item_s1.bin_index <= item_s1.last_good)
		&& (32'(item_s1.bin_index) < MAX_BINS);
	assign trackable = in_win
		&& (item_s1.sample > $signed({{(SAMPLE_W-CODE_W){1'b0}}, cfg.folded}))
		&& (item_s1.sample < $signed({{(SAMPLE_W-INV_W){1'b0}}, cfg.invalid}));

	// Peak update, starting from the bias on a new cut.
	always_comb begin
		neg_base = item_s1.new_cut ? bias_s : neg_peak_q;
		pos_base = item_s1.new_cut ? bias_s : pos_peak_q;
		neg_next = neg_base;
		pos_next = pos_base;
		if (trackable) begin
			if (item_s1.sample < bias_s) begin
				if (item_s1.sample < neg_base) begin
					neg_next = item_s1.sample;
				end
			end else if (item_s1.sample > pos_base) begin
				pos_next = item_s1.sample;
			end
		end
	end

	assign level_next = in_win ? map_level(item_s1.sample, cfg.mode, cfg.bias) : '0;

	// Peak state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_peak_q <= $signed({{(SAMPLE_W-CODE_W){1'b0}}, BIAS_RESET});
			pos_peak_q <= $signed({{(SAMPLE_W-CODE_W){1'b0}}, BIAS_RESET});
		end else if (valid_s1 && advance) begin
			neg_peak_q <= neg_next;
			pos_peak_q <= pos_next;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			level_s2 <= level_next;
		end
	end

	assign out_valid = valid_s2;
	assign out_level = level_s2;
	assign out_neg   = neg_peak_q;
	assign out_pos   = pos_peak_q;

endmodule

/* design/velocity_bin_level_map_and_peak.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// velocity_bin_level_map_and_peak
// Maps biased radar velocity bins to display levels and tracks the peaks.
// ----------------------------------------------------------------------------
// Usage:
// Bins enter on the s_t* stream, one request per bin, with new_cut in
// s_tuser on the first bin of a cut. Each bin yields one result on the
// m_t* stream: its display level and the negative and positive peaks of
// the cut including this bin. The APB-style port sets the resolution
// mode, the zero bias and the folded and invalid codes; write it only
// while no bin is in flight.
// m_tvalid rises once the result register holds the bin's result: the
// input register takes the accepted bin, mapping and peak compare run
// combinationally, and the result register takes the result. One bin is
// taken every cycle while m_tready stays high; the peak registers update
// with the result register, so consecutive bins do not wait on them.
// When the receiver stalls, the result register holds and the input
// register can still take one more bin; s_tready then drops.
// Reset clears both stages and loads the peaks and registers with their
// defaults (bias 129).
// ----------------------------------------------------------------------------
module velocity_bin_level_map_and_peak
	import vbl_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// APB-style configuration port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]   prdata,
	output logic                 pready,
	// Input stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// sample[15:0], bin_index[25:16], first_good[35:26], last_good[45:36], zero pad
	input  logic [S_TDATA_W-1:0] s_tdata,
	// new_cut[0]
	input  logic                 s_tuser,
	// Output stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// level[7:0], peak_negative[23:8], peak_positive[39:24]
	output logic [M_TDATA_W-1:0] m_tdata
);

	vbl_cfg_t                   cfg;
	vbl_item_t                  item;
	logic [LEVEL_W-1:0]         level;
	logic signed [SAMPLE_W-1:0] peak_negative;
	logic signed [SAMPLE_W-1:0] peak_positive;

	// Unpack the request.
	assign item.sample     = $signed(s_tdata[15:0]);
	assign item.bin_index  = s_tdata[25:16];
	assign item.first_good = s_tdata[35:26];
	assign item.last_good  = s_tdata[45:36];
	assign item.new_cut    = s_tuser;

	vbl_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	vbl_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (item),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_level (level),
		.out_neg   (peak_negative),
		.out_pos   (peak_positive)
	);

	// Pack the result.
	assign m_tdata = {peak_positive, peak_negative, level};

endmodule

/* design/vbl_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbl_checker
// Port-level checks on the level map and peak tracker.
// ----------------------------------------------------------------------------
module vbl_checker
	import vbl_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	// A stalled result keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// With the result register empty the block always takes a request.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked while output empty");

	// A result appears only after a request was taken.
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid && !(s_tvalid && s_tready) ##1 !m_tvalid |=> !m_tvalid)
		else $error("result without a request");

	// The negative peak never exceeds the positive peak.
	a_peak_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $signed(m_tdata[23:8]) <= $signed(m_tdata[39:24]))
		else $error("peak order broken");

endmodule

bind velocity_bin_level_map_and_peak vbl_checker u_vbl_checker (.*);

/* tb/sv/tb_velocity_bin_level_map_and_peak.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_velocity_bin_level_map_and_peak
// Self-checking testbench for the velocity bin level map and peak tracker.
// Bins are streamed in with random gaps while the result side stalls at
// random. A local model maps each accepted bin to its display level and
// tracks the cut peaks, and every result is compared against it in order.
// Directed bins cover the field extremes, both resolution modes, the unused
// mode codes, window edges, empty windows and a zero bias change. Random
// radials then run under a series of register settings, followed by a long
// output stall and a final stretch with no idling.
// ----------------------------------------------------------------------------
module tb_velocity_bin_level_map_and_peak;
	import vbl_pkg::*;

	localparam logic [MODE_W-1:0] MODE_ONE_MPS   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 2'd0;
	localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 2'd3;
	localparam int SETTLE_CYCLES  = 8;
	localparam int LONG_HOLD      = 64;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int REPORT_LIMIT   = 10;

	typedef struct packed {
		logic [LEVEL_W-1:0]  level;
		logic [SAMPLE_W-1:0] peak_negative;
		logic [SAMPLE_W-1:0] peak_positive;
	} bin_result_t;

	logic                 clk;
	logic                 arst_n   = 1'b0;
	logic                 psel     = 1'b0;
	logic                 penable  = 1'b0;
	logic                 pwrite   = 1'b0;
	logic [PADDR_W-1:0]   paddr    = '0;
	logic [PDATA_W-1:0]   pwdata   = '0;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	// sample[15:0], bin_index[25:16], first_good[35:26], last_good[45:36], zero pad
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	// new_cut[0]
	logic                 s_tuser  = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	// level[7:0], peak_negative[23:8], peak_positive[39:24]
	logic [M_TDATA_W-1:0] m_tdata;

	// Register copies and peak state of the local model.
	logic [MODE_W-1:0] cfg_mode    = MODE_RESET;
	logic [CODE_W-1:0] cfg_bias    = BIAS_RESET;
	logic [CODE_W-1:0] cfg_folded  = FOLDED_RESET;
	logic [INV_W-1:0]  cfg_invalid = INVALID_RESET;
	int                cut_neg_peak = int'(BIAS_RESET);
	int                cut_pos_peak = int'(BIAS_RESET);

	bin_result_t expected_bins[$];
	int          fail_count    = 0;
	int          stall_cycles  = 0;
	bit          idle_en       = 1'b1;
	bit          long_hold_req = 1'b0;

	// Position within the current random radial.
	int radial_pos   = 0;
	int radial_len   = 0;
	int radial_first = 0;
	int radial_last  = 0;
	bit cut_pending  = 1'b0;

	velocity_bin_level_map_and_peak u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic void note_failure(input string msg);
		fail_count++;
		if (fail_count <= REPORT_LIMIT) begin
			$display("%0t ERROR: %s", $time, msg);
		end
	endfunction

	function automatic vbl_item_t make_bin(input int sample, input int bin,
		input int first, input int last, input bit cut);
		vbl_item_t it;
		it.sample     = sample[SAMPLE_W-1:0];
		it.bin_index  = bin[BIN_W-1:0];
		it.first_good = first[BIN_W-1:0];
		it.last_good  = last[BIN_W-1:0];
		it.new_cut    = cut;
		return it;
	endfunction

	// Level mapping and peak tracking for one accepted bin.
	function automatic bin_result_t map_and_track(input vbl_item_t it);
		bin_result_t r;
		int s;
		int b;
		int p;
		s = int'($signed(it.sample));
		b = int'(cfg_bias);
		if (it.new_cut) begin
			cut_neg_peak = b;
			cut_pos_peak = b;
		end
		r.level = '0;
		if (it.bin_index >= it.first_good && it.bin_index <= it.last_good &&
			int'(it.bin_index) < MAX_BINS) begin
			if (s < 0 || s > 255) begin
				r.level = '0;
			end else if (cfg_mode == MODE_HALF_MPS || s <= 1) begin
				r.level = s[LEVEL_W-1:0];
			end else begin
				// Double the offset from zero bias, then clamp.
				p = (s - b) * 2 + b;
				if (p < int'(LEVEL_MIN)) begin
					p = int'(LEVEL_MIN);
				end else if (p > int'(LEVEL_MAX)) begin
					p = int'(LEVEL_MAX);
				end
				r.level = p[LEVEL_W-1:0];
			end
			// Only samples strictly between the folded and invalid codes count.
			if (s > int'(cfg_folded) && s < int'(cfg_invalid)) begin
				if (s < b) begin
					if (s < cut_neg_peak) begin
						cut_neg_peak = s;
					end
				end else if (s > cut_pos_peak) begin
					cut_pos_peak = s;
				end
			end
		end
		r.peak_negative = cut_neg_peak[SAMPLE_W-1:0];
		r.peak_positive = cut_pos_peak[SAMPLE_W-1:0];
		return r;
	endfunction

	// Next bin of a random radial; now and then a fully random bin instead.
	function automatic vbl_item_t next_radial_bin();
		vbl_item_t it;
		int s;
		bit cut;
		if ($urandom_range(0, 9) == 0) begin
			it.sample     = SAMPLE_W'($urandom());
			it.bin_index  = BIN_W'($urandom());
			it.first_good = BIN_W'($urandom());
			it.last_good  = BIN_W'($urandom());
			it.new_cut    = 1'($urandom());
			return it;
		end
		if (radial_pos >= radial_len) begin
			radial_pos = 0;
			radial_len = $urandom_range(8, 48);
			if ($urandom_range(0, 9) == 0) begin
				radial_first = $urandom_range(1, 12);
				radial_last  = $urandom_range(0, radial_first - 1);
			end else begin
				radial_first = $urandom_range(0, 12);
				radial_last  = $urandom_range(radial_first, radial_len + 4);
			end
			cut_pending = ($urandom_range(0, 3) == 0);
		end
		case ($urandom_range(0, 19))
			0: begin
				s = int'($signed(SAMPLE_W'($urandom())));
			end
			1, 2: begin
				case ($urandom_range(0, 5))
					0: s = int'(cfg_folded);
					1: s = int'(cfg_folded) + 1;
					2: s = int'(cfg_bias);
					3: s = int'(cfg_bias) - 1;
					4: s = int'(cfg_invalid) - 1;
					default: s = int'(cfg_invalid);
				endcase
			end
			default: begin
				s = $urandom_range(0, 255);
			end
		endcase
		cut = (radial_pos == 0) && cut_pending;
		it = make_bin(s, radial_pos, radial_first, radial_last, cut);
		radial_pos++;
		return it;
	endfunction

	// Offer one bin, with an occasional gap first, and predict its result.
	task automatic send_bin(input vbl_item_t it);
		int gap;
		if (idle_en && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 4);
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, it.last_good, it.first_good, it.bin_index, it.sample};
		s_tuser  <= it.new_cut;
		do @(posedge clk); while (!s_tready);
		expected_bins.push_back(map_and_track(it));
	endtask

	// Stop offering and wait until every predicted result has arrived.
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_bins.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_transfer(input logic wr, input logic [1:0] idx,
		input logic [PDATA_W-1:0] wdata, output logic [PDATA_W-1:0] rdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic check_register(input logic [1:0] idx, input logic [PDATA_W-1:0] want);
		logic [PDATA_W-1:0] rd;
		apb_transfer(1'b0, idx, '0, rd);
		if (rd !== want) begin
			note_failure($sformatf("register %0d read exp %h got %h", idx, want, rd));
		end
	endtask

	// Write all four registers with junk in the unused upper bits, then read back.
	task automatic program_config(input logic [MODE_W-1:0] mode,
		input logic [CODE_W-1:0] bias, input logic [CODE_W-1:0] folded,
		input logic [INV_W-1:0] invalid);
		logic [PDATA_W-1:0] junk;
		logic [PDATA_W-1:0] rd;
		drain();
		junk = $urandom();
		apb_transfer(1'b1, REG_MODE, {junk[PDATA_W-1:MODE_W], mode}, rd);
		junk = $urandom();
		apb_transfer(1'b1, REG_BIAS, {junk[PDATA_W-1:CODE_W], bias}, rd);
		junk = $urandom();
		apb_transfer(1'b1, REG_FOLDED, {junk[PDATA_W-1:CODE_W], folded}, rd);
		junk = $urandom();
		apb_transfer(1'b1, REG_INVALID, {junk[PDATA_W-1:INV_W], invalid}, rd);
		cfg_mode    = mode;
		cfg_bias    = bias;
		cfg_folded  = folded;
		cfg_invalid = invalid;
		check_register(REG_MODE, PDATA_W'(cfg_mode));
		check_register(REG_BIAS, PDATA_W'(cfg_bias));
		check_register(REG_FOLDED, PDATA_W'(cfg_folded));
		check_register(REG_INVALID, PDATA_W'(cfg_invalid));
	endtask

	// Half-speed pass-through at reset settings: field extremes and window edges.
	task automatic test_pass_through();
		send_bin(make_bin(129, 0, 0, 1023, 1'b1));
		send_bin(make_bin(0, 1, 0, 1023, 1'b0));
		send_bin(make_bin(1, 2, 0, 1023, 1'b0));
		send_bin(make_bin(2, 3, 0, 1023, 1'b0));
		send_bin(make_bin(255, 1023, 0, 1023, 1'b0));
		send_bin(make_bin(256, 4, 0, 1023, 1'b0));
		send_bin(make_bin(-1, 5, 0, 1023, 1'b0));
		send_bin(make_bin(-32768, 6, 0, 1023, 1'b0));
		send_bin(make_bin(32767, 7, 0, 1023, 1'b0));
		send_bin(make_bin(100, 4, 5, 9, 1'b0));
		send_bin(make_bin(100, 5, 5, 9, 1'b1));
		send_bin(make_bin(200, 9, 5, 9, 1'b0));
		send_bin(make_bin(50, 10, 5, 9, 1'b0));
		// Empty window: first good bin past the last good bin.
		send_bin(make_bin(60, 7, 9, 5, 1'b0));
	endtask

	// Doubling about the zero bias with both clamps.
	task automatic test_doubling_mode();
		program_config(MODE_ONE_MPS, BIAS_RESET, FOLDED_RESET, INVALID_RESET);
		send_bin(make_bin(0, 0, 0, 1023, 1'b1));
		send_bin(make_bin(1, 1, 0, 1023, 1'b0));
		send_bin(make_bin(2, 2, 0, 1023, 1'b0));
		send_bin(make_bin(100, 3, 0, 1023, 1'b0));
		send_bin(make_bin(129, 4, 0, 1023, 1'b0));
		send_bin(make_bin(192, 5, 0, 1023, 1'b0));
		send_bin(make_bin(255, 6, 0, 1023, 1'b0));
	endtask

	// Unused mode codes act as doubling; a new bias reaches the peaks at the next cut.
	task automatic test_unused_modes_and_bias();
		program_config(MODE_UNUSED_LO, BIAS_RESET, FOLDED_RESET, INVALID_RESET);
		send_bin(make_bin(150, 0, 0, 1023, 1'b1));
		program_config(MODE_UNUSED_HI, BIAS_RESET, FOLDED_RESET, INVALID_RESET);
		send_bin(make_bin(150, 1, 0, 1023, 1'b0));
		program_config(MODE_UNUSED_HI, 8'd200, FOLDED_RESET, INVALID_RESET);
		send_bin(make_bin(150, 2, 0, 1023, 1'b0));
		send_bin(make_bin(150, 3, 0, 1023, 1'b1));
	endtask

	// Random radials under extreme, typical and fully random register settings.
	task automatic test_random_configs();
		for (int ph = 0; ph < 12; ph++) begin
			case (ph)
				0: program_config(MODE_ONE_MPS, 8'd0, 8'd0, 10'd1023);
				1: program_config(MODE_HALF_MPS, 8'd255, 8'd255, 10'd0);
				2: program_config(MODE_UNUSED_LO, 8'd255, 8'd0, 10'd1023);
				3: program_config(MODE_UNUSED_HI, 8'd0, 8'd255, 10'd0);
				default: begin
					if ($urandom_range(0, 2) == 0) begin
						program_config(MODE_W'($urandom()), CODE_W'($urandom()),
							CODE_W'($urandom()), INV_W'($urandom()));
					end else begin
						program_config($urandom_range(0, 1) ? MODE_HALF_MPS : MODE_ONE_MPS,
							CODE_W'($urandom_range(100, 160)), CODE_W'($urandom_range(0, 4)),
							INV_W'($urandom_range(250, 300)));
					end
				end
			endcase
			idle_en = ($urandom_range(0, 3) != 0);
			repeat (100) send_bin(next_radial_bin());
		end
	endtask

	// The receiver holds off for a long stretch while bins keep coming.
	task automatic test_output_backpressure();
		program_config(MODE_ONE_MPS, BIAS_RESET, FOLDED_RESET, INVALID_RESET);
		idle_en = 1'b0;
		long_hold_req = 1'b1;
		repeat (120) send_bin(next_radial_bin());
	endtask

	// Full-rate stream with no idling on either side.
	task automatic test_steady_stream();
		program_config(MODE_HALF_MPS, CODE_W'($urandom_range(100, 160)), FOLDED_RESET,
			INVALID_RESET);
		idle_en = 1'b0;
		repeat (220) send_bin(next_radial_bin());
	endtask

	// Result side ready: random stall bursts, or one long hold when requested.
	initial begin : result_receiver
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(0, 3)) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Compare each accepted result with the oldest prediction.
	always @(posedge clk) begin : result_check
		bin_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_bins.size() == 0) begin
				note_failure($sformatf("result with nothing pending: %h", m_tdata));
			end else begin
				want = expected_bins.pop_front();
				if (m_tdata[7:0] !== want.level || m_tdata[23:8] !== want.peak_negative ||
					m_tdata[39:24] !== want.peak_positive) begin
					note_failure($sformatf(
						"level exp %0d got %0d, neg peak exp %0d got %0d, pos peak exp %0d got %0d",
						want.level, m_tdata[7:0], $signed(want.peak_negative),
						$signed(m_tdata[23:8]), $signed(want.peak_positive),
						$signed(m_tdata[39:24])));
				end
			end
		end
	end

	// End the run if no request moves on either stream for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
				if (stall_cycles >= WATCHDOG_LIMIT) begin
					$display("tb_velocity_bin_level_map_and_peak failed");
					$finish;
				end
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_pass_through();
		test_doubling_mode();
		test_unused_modes_and_bias();
		test_random_configs();
		test_output_backpressure();
		test_steady_stream();
		drain();
		if (expected_bins.size() != 0) begin
			note_failure($sformatf("%0d results never arrived", expected_bins.size()));
		end
		if (fail_count == 0) begin
			$display("tb_velocity_bin_level_map_and_peak passed");
		end else begin
			$display("tb_velocity_bin_level_map_and_peak failed");
		end
		$finish;
	end

endmodule

/* sim.f */
design/vbl_pkg.sv
design/vbl_cfg.sv
design/vbl_core.sv
design/velocity_bin_level_map_and_peak.sv
design/vbl_checker.sv
tb/sv/tb_velocity_bin_level_map_and_peak.sv
